[sv/dlar_pkg.sv]
package dlar_pkg;

    // default sizes
    localparam int LEASE_ENTRIES_DEF = 64;
    localparam int ID_BYTES_DEF      = 16;

    // message types acted on
    localparam logic [3:0] CMD_DISCOVER = 4'd1;
    localparam logic [3:0] CMD_REQUEST  = 4'd3;

    // reply types
    localparam logic [1:0] RT_OFFER = 2'd0;
    localparam logic [1:0] RT_ACK   = 2'd1;
    localparam logic [1:0] RT_NAK   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SERVER_ADDR = 2'd0;
    localparam logic [1:0] CFG_POOL_LOW    = 2'd1;
    localparam logic [1:0] CFG_POOL_HIGH   = 2'd2;

    localparam logic [31:0] ALL_ONES_ADDR = 32'hFFFF_FFFF;

    // one lease table entry
    typedef struct packed {
        logic        valid;
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [4:0]  id_len;
        logic [31:0] addr;
    } dlar_entry_t;

    // ring control
    typedef struct packed {
        logic shift;
        logic load;
    } dlar_ring_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_CAND,
        ST_SCAN,
        ST_INSERT,
        ST_REPLY
    } dlar_state_t;

    // keep identifier bytes 0 to 7 below the length
    function automatic logic [63:0] id_mask_high(input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            m[63 - 8*b -: 8] = (n > 5'(b)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // keep identifier bytes 8 to 15 below the length
    function automatic logic [63:0] id_mask_low(input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            m[63 - 8*b -: 8] = (n > 5'(b + 8)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[sv/dlar_if.sv]
interface dlar_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [63:0] client_id_high;
    logic [63:0] client_id_low;
    logic [4:0]  client_id_len;
    logic        requested_ip_present;
    logic [31:0] requested_ip;
    logic        server_id_present;
    logic [31:0] server_id;
    logic [31:0] client_addr;
    logic [31:0] relay_addr;
    logic [31:0] your_addr_in;
    logic        bcast_flag;

    modport source (
        output valid, cmd, client_id_high, client_id_low, client_id_len,
               requested_ip_present, requested_ip, server_id_present, server_id,
               client_addr, relay_addr, your_addr_in, bcast_flag,
        input  ready
    );
    modport sink (
        input  valid, cmd, client_id_high, client_id_low, client_id_len,
               requested_ip_present, requested_ip, server_id_present, server_id,
               client_addr, relay_addr, your_addr_in, bcast_flag,
        output ready
    );
endinterface

interface dlar_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reply_type;
    logic [31:0] assigned_addr;
    logic [31:0] dest_addr;
    logic        set_broadcast;

    modport source (
        output valid, reply_type, assigned_addr, dest_addr, set_broadcast,
        input  ready
    );
    modport sink (
        input  valid, reply_type, assigned_addr, dest_addr, set_broadcast,
        output ready
    );
endinterface

[sv/dlar_cell.sv]
module dlar_cell
    import dlar_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  dlar_entry_t    din,
    output dlar_entry_t    dout
);

    logic        valid_reg;
    logic [63:0] id_high_reg;
    logic [63:0] id_low_reg;
    logic [4:0]  id_len_reg;
    logic [31:0] addr_reg;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= din.valid;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            id_high_reg <= din.id_high;
            id_low_reg  <= din.id_low;
            id_len_reg  <= din.id_len;
            addr_reg    <= din.addr;
        end
    end

    assign dout = {valid_reg, id_high_reg, id_low_reg, id_len_reg, addr_reg};

endmodule

[sv/dlar_ring.sv]
module dlar_ring
    import dlar_pkg::*;
#(
    parameter int LEASE_ENTRIES = LEASE_ENTRIES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  dlar_ring_ctl_t ctl,
    input  dlar_entry_t    wr_entry,
    output dlar_entry_t    head
);

    dlar_entry_t cell_out [LEASE_ENTRIES];
    dlar_entry_t cell_in  [LEASE_ENTRIES];

    // each cell takes its upper neighbor; the tail takes the head or a new entry
    genvar g;
    generate
        for (g = 0; g < LEASE_ENTRIES; g++)
        begin : g_cell
            if (g == LEASE_ENTRIES - 1)
            begin : g_tail
                assign cell_in[g] = ctl.load ? wr_entry : cell_out[0];
            end
            else
            begin : g_body
                assign cell_in[g] = cell_out[g + 1];
            end

            dlar_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ctl.shift),
                .din   (cell_in[g]),
                .dout  (cell_out[g])
            );
        end
    endgenerate

    assign head = cell_out[0];

endmodule

[sv/dhcp_lease_allocate_and_reply_unit.sv]
// channel   dir  handshake     word
// req       in   valid/ready   parsed request: cmd, client id, options, ciaddr, giaddr, yiaddr
// rsp       out  valid/ready   reply_type, assigned_addr, dest_addr, set_broadcast
// cfg       in   cfg_we        cfg_index, cfg_wdata (server_addr, pool_low, pool_high)
//
// the lease table is a ring of LEASE_ENTRIES cells that rotates one place a cycle during a pass
// a request or known discover takes one ring pass
// a new client's discover adds one ring pass per checked pool address and one to insert
// reset empties the table at once; no clearing pass
// a finished reply waits in the output register while the next word runs; the next
// reply stalls until it is taken
module dhcp_lease_allocate_and_reply_unit
    import dlar_pkg::*;
#(
    parameter int LEASE_ENTRIES = LEASE_ENTRIES_DEF,
    parameter int ID_BYTES      = ID_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    dlar_req_if.sink          req,
    dlar_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata
);

    localparam int SW = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
    localparam int NW = $clog2(LEASE_ENTRIES + 4);
    localparam logic [SW-1:0] LAST_STEP = SW'(LEASE_ENTRIES - 1);
    localparam logic [32:0]   LIMIT_MAX = 33'(LEASE_ENTRIES + 3);

    dlar_state_t state_reg, state_next;

    logic [31:0] server_addr_reg, pool_low_reg, pool_high_reg, last_offer_reg;

    // latched request
    logic [3:0]  cmd_reg;
    logic [63:0] idh_reg, idl_reg;
    logic [4:0]  len_reg;
    logic        rq_present_reg, sid_present_reg, bflag_reg;
    logic [31:0] rq_ip_reg, sid_reg, ciaddr_reg, giaddr_reg, yiaddr_reg;

    // search state
    logic [SW-1:0] step_reg, free_idx_reg;
    logic          known_reg, free_found_reg, inuse_reg;
    logic [31:0]   prev_reg, cand_reg;
    logic [NW-1:0] n_reg, limit_reg;
    logic [1:0]    rtype_reg;
    logic [31:0]   assigned_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_type_reg;
    logic [31:0] out_assigned_reg, out_dest_reg;
    logic        out_bcast_reg;

    dlar_ring_ctl_t ring_ctl;
    dlar_entry_t    head, wr_entry;

    logic [4:0]  len_eff;
    logic        accept, last_step, head_match, head_inuse, out_free;
    logic [32:0] cand_first, pool_size;
    logic [31:0] cand_adv;
    logic        req_sid_ok, req_other, req_ack;
    logic [31:0] dest;

    assign accept    = req.valid && req.ready;
    assign last_step = (step_reg == LAST_STEP);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign len_eff   = (req.client_id_len > 5'(ID_BYTES)) ? 5'(ID_BYTES) : req.client_id_len;

    // head compare against the key and the candidate
    assign head_match = (len_reg != 5'd0) && head.valid && (head.id_len == len_reg)
                        && (head.id_high == idh_reg) && (head.id_low == idl_reg);
    assign head_inuse = head.valid && (head.addr == cand_reg);

    // candidate start and pool size
    always_comb
    begin
        cand_first = {1'b0, last_offer_reg} + 33'd1;
        if (cand_first > {1'b0, pool_high_reg} || cand_first < {1'b0, pool_low_reg})
        begin
            cand_first = {1'b0, pool_low_reg};
        end
        pool_size = {1'b0, pool_high_reg} - {1'b0, pool_low_reg} + 33'd1;
    end
    assign cand_adv = (cand_reg >= pool_high_reg) ? pool_low_reg : cand_reg + 32'd1;

    // request decision
    assign req_sid_ok = sid_present_reg && (sid_reg == server_addr_reg);
    assign req_other  = rq_present_reg || (ciaddr_reg != 32'd0);
    assign req_ack    = req_sid_ok ? known_reg
                      : (known_reg && ((rq_present_reg && prev_reg == rq_ip_reg)
                                       || prev_reg == ciaddr_reg));

    // destination
    always_comb
    begin
        if (giaddr_reg != 32'd0)
        begin
            dest = giaddr_reg;
        end
        else if (rtype_reg == RT_NAK)
        begin
            dest = ALL_ONES_ADDR;
        end
        else if (ciaddr_reg != 32'd0)
        begin
            dest = ciaddr_reg;
        end
        else if (bflag_reg || yiaddr_reg == 32'd0)
        begin
            dest = ALL_ONES_ADDR;
        end
        else
        begin
            dest = yiaddr_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == CMD_DISCOVER || req.cmd == CMD_REQUEST))
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (last_step)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (cmd_reg == CMD_DISCOVER)
                begin
                    if (known_reg)
                    begin
                        state_next = ST_REPLY;
                    end
                    else if (!free_found_reg || pool_low_reg > pool_high_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CAND;
                    end
                end
                else if (req_sid_ok || req_other)
                begin
                    state_next = ST_REPLY;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CAND:
            begin
                if (n_reg == limit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!(cand_reg == 32'd0 || cand_reg == server_addr_reg))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = (inuse_reg || head_inuse) ? ST_CAND : ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (last_step)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ring_ctl.shift = 1'b0;
        ring_ctl.load  = 1'b0;
        case (state_reg)
            ST_LOOKUP, ST_SCAN:
            begin
                ring_ctl.shift = 1'b1;
            end
            ST_INSERT:
            begin
                ring_ctl.shift = 1'b1;
                ring_ctl.load  = (step_reg == free_idx_reg);
            end
            default:
            begin
                ring_ctl.shift = 1'b0;
            end
        endcase
    end

    assign wr_entry.valid   = 1'b1;
    assign wr_entry.id_high = idh_reg;
    assign wr_entry.id_low  = idl_reg;
    assign wr_entry.id_len  = len_reg;
    assign wr_entry.addr    = cand_reg;

    assign req.ready = (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers and last offer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_addr_reg <= '0;
            pool_low_reg    <= '0;
            pool_high_reg   <= '0;
            last_offer_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SERVER_ADDR: server_addr_reg <= cfg_wdata;
                    CFG_POOL_LOW:    pool_low_reg    <= cfg_wdata;
                    CFG_POOL_HIGH:
                    begin
                        pool_high_reg  <= cfg_wdata;
                        last_offer_reg <= cfg_wdata;
                    end
                    default:
                    begin
                        server_addr_reg <= server_addr_reg;
                    end
                endcase
            end
            if (state_reg == ST_INSERT && last_step)
            begin
                last_offer_reg <= cand_reg;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg         <= req.cmd;
            len_reg         <= len_eff;
            idh_reg         <= req.client_id_high & id_mask_high(len_eff);
            idl_reg         <= req.client_id_low & id_mask_low(len_eff);
            rq_present_reg  <= req.requested_ip_present;
            rq_ip_reg       <= req.requested_ip;
            sid_present_reg <= req.server_id_present;
            sid_reg         <= req.server_id;
            ciaddr_reg      <= req.client_addr;
            giaddr_reg      <= req.relay_addr;
            yiaddr_reg      <= req.your_addr_in;
            bflag_reg       <= req.bcast_flag;
        end
    end

    // search bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            known_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            inuse_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg       <= '0;
                    known_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                ST_LOOKUP:
                begin
                    step_reg <= last_step ? '0 : step_reg + SW'(1);
                    if (head_match && !known_reg)
                    begin
                        known_reg <= 1'b1;
                    end
                    if (!head.valid && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
                ST_CAND:
                begin
                    step_reg  <= '0;
                    inuse_reg <= 1'b0;
                end
                ST_SCAN, ST_INSERT:
                begin
                    step_reg <= last_step ? '0 : step_reg + SW'(1);
                    if (head_inuse)
                    begin
                        inuse_reg <= 1'b1;
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // search payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOOKUP:
            begin
                if (head_match && !known_reg)
                begin
                    prev_reg <= head.addr;
                end
                if (!head.valid && !free_found_reg)
                begin
                    free_idx_reg <= step_reg;
                end
            end
            ST_DECIDE:
            begin
                cand_reg <= cand_first[31:0];
                n_reg    <= '0;
                limit_reg <= (pool_size < LIMIT_MAX) ? pool_size[NW-1:0] : LIMIT_MAX[NW-1:0];
                if (cmd_reg == CMD_DISCOVER)
                begin
                    rtype_reg    <= RT_OFFER;
                    assigned_reg <= prev_reg;
                end
                else
                begin
                    rtype_reg    <= req_ack ? RT_ACK : RT_NAK;
                    assigned_reg <= req_ack ? prev_reg : 32'd0;
                end
            end
            ST_CAND:
            begin
                if (n_reg != limit_reg && (cand_reg == 32'd0 || cand_reg == server_addr_reg))
                begin
                    cand_reg <= cand_adv;
                    n_reg    <= n_reg + NW'(1);
                end
            end
            ST_SCAN:
            begin
                if (last_step && (inuse_reg || head_inuse))
                begin
                    cand_reg <= cand_adv;
                    n_reg    <= n_reg + NW'(1);
                end
            end
            ST_INSERT:
            begin
                assigned_reg <= cand_reg;
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_REPLY && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REPLY && out_free)
        begin
            out_type_reg     <= rtype_reg;
            out_assigned_reg <= assigned_reg;
            out_dest_reg     <= dest;
            out_bcast_reg    <= (giaddr_reg != 32'd0);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.reply_type    = out_type_reg;
    assign rsp.assigned_addr = out_assigned_reg;
    assign rsp.dest_addr     = out_dest_reg;
    assign rsp.set_broadcast = out_bcast_reg;

    dlar_ring #(
        .LEASE_ENTRIES (LEASE_ENTRIES)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ring_ctl),
        .wr_entry (wr_entry),
        .head     (head)
    );

`ifndef SYNTH
    // a lookup pass ends after exactly one ring turn
    a_lookup_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && last_step) |=> (state_reg == ST_DECIDE))
        else $error("lookup pass did not end in decide");

    // an insert only happens with a free slot seen
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |-> free_found_reg)
        else $error("insert without a free slot");

    // a nak never carries an address
    a_nak_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.reply_type == RT_NAK) |-> (rsp.assigned_addr == 32'd0))
        else $error("nak with nonzero address");

    // ring only moves during passes
    a_ring_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_REPLY) |-> !ring_ctl.shift)
        else $error("ring moved outside a pass");
`endif

endmodule
